@@ design/self_test_led_status_sequencer_defines.svh @@
// Assertion macros for the self-test LED status sequencer.
// Used by the RTL file self_test_led_status_sequencer.sv under design; needs clk_i and rst_ni in scope.
`ifndef SELF_TEST_LED_STATUS_SEQUENCER_DEFINES_SVH
`define SELF_TEST_LED_STATUS_SEQUENCER_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define STLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define STLS_ASSERT_NEVER(lbl, cond, msg) \
  `STLS_ASSERT(lbl, !(cond), msg)

`endif

@@ design/stls_pkg.sv @@
// Package for the self-test LED status sequencer: status, command and
// configuration register codes. No dependencies.
`timescale 1ns / 1ps

package stls_pkg;

  typedef enum logic [2:0] {
    ST_POSTING     = 3'd0,
    ST_BEFORE_INIT = 3'd1,
    ST_ERROR       = 3'd2,
    ST_ENDED       = 3'd3,
    ST_SUCCESS     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_START_INIT  = 3'd1,
    CMD_SUCCESS     = 3'd2,
    CMD_ERROR       = 3'd3,
    CMD_PANIC_CHECK = 3'd4,
    CMD_BLINK_STEP  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_POSTING_TIMEOUT = 2'd0,
    CFG_INIT_TIMEOUT    = 2'd1,
    CFG_PATTERN_MODE    = 2'd2
  } cfg_addr_e;

  localparam logic [31:0] POSTING_TIMEOUT_RST = 32'd12000;
  localparam logic [31:0] INIT_TIMEOUT_RST    = 32'd6000;

endpackage

@@ design/self_test_led_status_sequencer.sv @@
// Self-test LED status sequencer: an input register and a result register with
// the status update between them. Throughput is one request per cycle while the
// consumer does not stall; the state updates as the result register loads, so
// back-to-back requests see each other's state. Reset (rst_ni low, asynchronous)
// clears the sequencer state, valid flags and config to defaults.
`timescale 1ns / 1ps

module self_test_led_status_sequencer #(
  parameter int unsigned BLINK_INTERVAL = 100,
  parameter int unsigned PANIC_PERIOD   = 1000
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_addr_i,
  input  logic [31:0]                cfg_wdata_i,
  // Request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 command_i,
  input  logic [31:0]                tick_time_i,
  input  logic [30:0]                panic_count_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 status_code_o,
  output logic                       power_green_o,
  output logic                       power_red_o,
  output logic                       aux_leds_o,
  output logic                       time_ended_o
);

  import stls_pkg::*;

  `include "self_test_led_status_sequencer_defines.svh"

  // Number of trailing zero bits of a constant.
  function automatic int unsigned tz_count(input int unsigned v);
    int unsigned n;
    int unsigned x;
    n = 0;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x != 0 && x[0] == 1'b0) begin
        x = x >> 1;
        n = n + 1;
      end
    end
    return n;
  endfunction

  // Inverse of an odd constant modulo 2^32 by Newton iteration.
  function automatic logic [31:0] inv32(input logic [31:0] o);
    logic [31:0] y;
    y = o;
    for (int i = 0; i < 5; i++) begin
      y = y * (32'd2 - o * y);
    end
    return y;
  endfunction

  // A value is a multiple of 2^k * odd when its low k bits are zero and the
  // remaining part times the inverse of odd lands at or below (2^N-1)/odd.
  localparam int unsigned BLINK_SH   = tz_count(BLINK_INTERVAL);
  localparam int unsigned BLINK_ODD  = BLINK_INTERVAL >> BLINK_SH;
  localparam logic [31:0] BLINK_INV  = inv32(32'(BLINK_ODD));
  localparam logic [31:0] BLINK_LIM  = 32'(64'hFFFF_FFFF / BLINK_ODD);
  localparam logic [31:0] BLINK_MASK = 32'((64'd1 << BLINK_SH) - 64'd1);

  localparam int unsigned PANIC_SH   = tz_count(PANIC_PERIOD);
  localparam int unsigned PANIC_ODD  = PANIC_PERIOD >> PANIC_SH;
  localparam logic [30:0] PANIC_INV  = 31'(inv32(32'(PANIC_ODD)));
  localparam logic [30:0] PANIC_LIM  = 31'(64'h7FFF_FFFF / PANIC_ODD);
  localparam logic [30:0] PANIC_MASK = 31'((64'd1 << PANIC_SH) - 64'd1);

  // Configuration registers
  logic [31:0] posting_timeout_q;
  logic [31:0] init_timeout_q;
  logic        pattern_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posting_timeout_q <= POSTING_TIMEOUT_RST;
      init_timeout_q    <= INIT_TIMEOUT_RST;
      pattern_mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_POSTING_TIMEOUT: posting_timeout_q <= cfg_wdata_i;
        CFG_INIT_TIMEOUT:    init_timeout_q    <= cfg_wdata_i;
        CFG_PATTERN_MODE:    pattern_mode_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic v1_q, out_valid_q;
  logic out_free, load1, load_out;

  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = v1_q && out_free;
  assign in_ready_o = !v1_q || out_free;
  assign load1      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= v1_q;
      end
    end
  end

  // Registered request
  logic [2:0]  cmd1_q;
  logic [31:0] t1_q;
  logic [30:0] cnt1_q;

  always_ff @(posedge clk_i) begin
    if (load1) begin
      cmd1_q <= command_i;
      t1_q   <= tick_time_i;
      cnt1_q <= panic_count_i;
    end
  end

  // Divisibility checks by reciprocal multiplication
  logic [31:0] blink_prod;
  logic [30:0] panic_prod;
  logic        blink_low_ok;
  logic        panic_low_ok;

  assign blink_prod   = (t1_q >> BLINK_SH) * BLINK_INV;
  assign panic_prod   = (cnt1_q >> PANIC_SH) * PANIC_INV;
  assign blink_low_ok = (t1_q & BLINK_MASK) == '0;
  assign panic_low_ok = (cnt1_q & PANIC_MASK) == '0;

  // Sequencer state
  status_e     status_q, status_d;
  logic [2:0]  phase_q, phase_d;
  logic [31:0] last_blink_q, last_blink_d;
  logic [31:0] init_start_q, init_start_d;
  logic        green_q, green_d;
  logic        red_q, red_d;
  logic        aux_q, aux_d;

  logic        blink_div, panic_div;
  logic [31:0] post_diff, blink_diff, init_diff;
  logic        post_late, blink_late, init_late;
  logic [2:0]  blk_phase;
  logic        blk_green;
  logic        err_bit;

  assign blink_div = blink_low_ok && (blink_prod <= BLINK_LIM);
  assign panic_div = panic_low_ok && (panic_prod <= PANIC_LIM);

  // Wrap-safe "a is after b": the difference is nonzero and below 2^31.
  assign post_diff  = t1_q - posting_timeout_q;
  assign blink_diff = t1_q - last_blink_q;
  assign init_diff  = t1_q - (init_start_q + init_timeout_q);
  assign post_late  = (post_diff != '0) && !post_diff[31];
  assign blink_late = (blink_diff != '0) && !blink_diff[31];
  assign init_late  = (init_diff != '0) && !init_diff[31];

  // Blink step and error light results, taken from the current state.
  always_comb begin
    if (pattern_mode_q) begin
      blk_phase = (phase_q >= 3'd4) ? 3'd0 : phase_q + 3'd1;
      if (phase_q == 3'd0) begin
        blk_green = 1'b1;
      end else if (phase_q == 3'd3) begin
        blk_green = 1'b0;
      end else begin
        blk_green = green_q;
      end
    end else begin
      blk_phase = {2'b00, phase_q == 3'd0};
      blk_green = phase_q == 3'd0;
    end
  end

  assign err_bit = phase_q == 3'd0;

  always_comb begin
    status_d     = status_q;
    phase_d      = phase_q;
    last_blink_d = last_blink_q;
    init_start_d = init_start_q;
    green_d      = green_q;
    red_d        = red_q;
    aux_d        = aux_q;
    case (cmd1_q)
      CMD_TICK: begin
        case (status_q)
          ST_POSTING: begin
            if (post_late) begin
              status_d = ST_ENDED;
              phase_d  = {2'b00, err_bit};
              aux_d    = err_bit;
              if (pattern_mode_q) begin
                red_d = err_bit;
              end else begin
                green_d = err_bit;
              end
            end else if (blink_late && blink_div) begin
              last_blink_d = t1_q;
              phase_d      = blk_phase;
              green_d      = blk_green;
            end
          end
          ST_BEFORE_INIT: begin
            if (init_late) begin
              status_d = ST_ENDED;
              green_d  = 1'b1;
              if (pattern_mode_q) begin
                red_d = 1'b0;
              end
            end else begin
              last_blink_d = t1_q;
              phase_d      = blk_phase;
              green_d      = blk_green;
            end
          end
          ST_ERROR: begin
            status_d = ST_ENDED;
            phase_d  = {2'b00, err_bit};
            aux_d    = err_bit;
            if (pattern_mode_q) begin
              red_d = err_bit;
            end else begin
              green_d = err_bit;
            end
          end
          default: ;
        endcase
      end
      CMD_START_INIT: begin
        init_start_d = t1_q;
        status_d     = ST_BEFORE_INIT;
      end
      CMD_SUCCESS: begin
        status_d = ST_SUCCESS;
        green_d  = 1'b1;
        if (pattern_mode_q) begin
          red_d = 1'b0;
        end
      end
      CMD_ERROR: begin
        status_d = ST_ERROR;
      end
      CMD_PANIC_CHECK: begin
        if (panic_div && status_q != ST_ENDED && status_q != ST_SUCCESS) begin
          status_d = ST_ERROR;
          phase_d  = {2'b00, err_bit};
          aux_d    = err_bit;
          if (pattern_mode_q) begin
            red_d = err_bit;
          end else begin
            green_d = err_bit;
          end
        end
      end
      CMD_BLINK_STEP: begin
        phase_d = blk_phase;
        green_d = blk_green;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q     <= ST_POSTING;
      phase_q      <= 3'd0;
      last_blink_q <= 32'd0;
      init_start_q <= 32'd0;
      green_q      <= 1'b0;
      red_q        <= 1'b0;
      aux_q        <= 1'b0;
    end else if (load_out) begin
      status_q     <= status_d;
      phase_q      <= phase_d;
      last_blink_q <= last_blink_d;
      init_start_q <= init_start_d;
      green_q      <= green_d;
      red_q        <= red_d;
      aux_q        <= aux_d;
    end
  end

  // Result register, held while the consumer stalls.
  logic [2:0] status_code_q;
  logic       green_out_q, red_out_q, aux_out_q, ended_out_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_code_q <= status_d;
      green_out_q   <= green_d;
      red_out_q     <= red_d;
      aux_out_q     <= aux_d;
      ended_out_q   <= status_d == ST_ENDED;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_code_o = status_code_q;
  assign power_green_o = green_out_q;
  assign power_red_o   = red_out_q;
  assign aux_leds_o    = aux_out_q;
  assign time_ended_o  = ended_out_q;

  `STLS_ASSERT(a_ended_flag,
    out_valid_o |-> (time_ended_o == (status_code_o == ST_ENDED)),
    "time_ended_o disagrees with status_code_o")
  `STLS_ASSERT(a_load_sets_valid, load_out |=> out_valid_q,
    "result stage loaded but not valid")
  `STLS_ASSERT(a_success_green, (load_out && cmd1_q == CMD_SUCCESS) |=> power_green_o,
    "success request did not light the green LED")
  `STLS_ASSERT_NEVER(a_phase_range, phase_q > 3'd4,
    "blink phase left its five-phase range")

endmodule

@@ dv/self_test_led_status_sequencer_test.sv @@
// Testbench for the self-test LED status sequencer: directed and random requests,
// with a scoreboard class that predicts every status result and checks it.
// Depends on stls_pkg and the self_test_led_status_sequencer RTL.
`timescale 1ns / 1ps

module self_test_led_status_sequencer_test;
  import stls_pkg::*;

  localparam logic [31:0] BLINK_INTERVAL = 32'd100;
  localparam logic [31:0] PANIC_PERIOD   = 32'd1000;
  localparam int          RANDOM_ITEMS   = 1100;
  localparam int          CYCLE_LIMIT    = 500000;

  typedef struct packed {
    logic [2:0] status_code;
    logic       power_green;
    logic       power_red;
    logic       aux_leds;
    logic       time_ended;
  } led_result_t;

  class led_scoreboard;
    logic [31:0] posting_timeout;
    logic [31:0] init_timeout;
    logic        pattern_mode;
    status_e     status;
    logic [2:0]  blink_phase;
    logic [31:0] last_blink_time;
    logic [31:0] init_start_time;
    logic        green;
    logic        red;
    logic        aux;
    led_result_t expected_leds[$];
    int          errors;
    int          matched;

    function new();
      posting_timeout = POSTING_TIMEOUT_RST;
      init_timeout    = INIT_TIMEOUT_RST;
      pattern_mode    = 1'b0;
      status          = ST_POSTING;
      blink_phase     = 3'd0;
      last_blink_time = 32'd0;
      init_start_time = 32'd0;
      green           = 1'b0;
      red             = 1'b0;
      aux             = 1'b0;
      errors          = 0;
      matched         = 0;
    endfunction

    function void write_cfg(cfg_addr_e addr, logic [31:0] data);
      case (addr)
        CFG_POSTING_TIMEOUT: posting_timeout = data;
        CFG_INIT_TIMEOUT:    init_timeout = data;
        CFG_PATTERN_MODE:    pattern_mode = data[0];
        default: ;
      endcase
    endfunction

    // Wrap-safe: a lies after b when a - b is in 1 .. 2^31-1.
    function bit later_than(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
    endfunction

    function void blink_step();
      if (pattern_mode) begin
        if (blink_phase == 3'd0) green = 1'b1;
        else if (blink_phase == 3'd3) green = 1'b0;
        blink_phase = (blink_phase == 3'd4) ? 3'd0 : blink_phase + 3'd1;
      end else begin
        blink_phase = (blink_phase == 3'd0) ? 3'd1 : 3'd0;
        green = blink_phase[0];
      end
    endfunction

    function void error_light();
      blink_phase = (blink_phase == 3'd0) ? 3'd1 : 3'd0;
      if (pattern_mode) red = blink_phase[0];
      else green = blink_phase[0];
      aux = blink_phase[0];
    endfunction

    function void success_light();
      green = 1'b1;
      if (pattern_mode) red = 1'b0;
    endfunction

    function void record_request(cmd_e cmd, logic [31:0] t, logic [30:0] cnt);
      led_result_t res;
      logic [31:0] deadline;
      deadline = init_start_time + init_timeout;
      case (cmd)
        CMD_TICK: begin
          if (status == ST_POSTING) begin
            if (later_than(t, posting_timeout)) begin
              status = ST_ENDED;
              error_light();
            end else if (later_than(t, last_blink_time) && (t % BLINK_INTERVAL) == 32'd0) begin
              last_blink_time = t;
              blink_step();
            end
          end else if (status == ST_BEFORE_INIT) begin
            if (later_than(t, deadline)) begin
              status = ST_ENDED;
              success_light();
            end else begin
              last_blink_time = t;
              blink_step();
            end
          end else if (status == ST_ERROR) begin
            status = ST_ENDED;
            error_light();
          end
        end
        CMD_START_INIT: begin
          init_start_time = t;
          status = ST_BEFORE_INIT;
        end
        CMD_SUCCESS: begin
          status = ST_SUCCESS;
          success_light();
        end
        CMD_ERROR: status = ST_ERROR;
        CMD_PANIC_CHECK: begin
          if (({1'b0, cnt} % PANIC_PERIOD) == 32'd0 &&
              status != ST_ENDED && status != ST_SUCCESS) begin
            status = ST_ERROR;
            error_light();
          end
        end
        CMD_BLINK_STEP: blink_step();
        default: ;
      endcase
      res.status_code = status;
      res.power_green = green;
      res.power_red   = red;
      res.aux_leds    = aux;
      res.time_ended  = (status == ST_ENDED);
      expected_leds.push_back(res);
    endfunction

    function void check_leds(logic [2:0] st, logic pg, logic pr, logic al, logic te);
      led_result_t exp;
      if (expected_leds.size() == 0) begin
        $error("status result with no request waiting: status_code %0d", st);
        errors++;
        return;
      end
      exp = expected_leds.pop_front();
      matched++;
      if (st !== exp.status_code) begin
        $error("status_code: expected %0d, actual %0d", exp.status_code, st);
        errors++;
      end
      if (pg !== exp.power_green) begin
        $error("power_green: expected %0d, actual %0d", exp.power_green, pg);
        errors++;
      end
      if (pr !== exp.power_red) begin
        $error("power_red: expected %0d, actual %0d", exp.power_red, pr);
        errors++;
      end
      if (al !== exp.aux_leds) begin
        $error("aux_leds: expected %0d, actual %0d", exp.aux_leds, al);
        errors++;
      end
      if (te !== exp.time_ended) begin
        $error("time_ended: expected %0d, actual %0d", exp.time_ended, te);
        errors++;
      end
    endfunction

    function int pending_count();
      return expected_leds.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_POSTING_TIMEOUT;
  logic [31:0] cfg_wdata = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = CMD_TICK;
  logic [31:0] tick_time = 32'd0;
  logic [30:0] panic_count = 31'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status_code;
  logic        power_green;
  logic        power_red;
  logic        aux_leds;
  logic        time_ended;

  led_scoreboard sb = new();

  int          requests_sent = 0;
  int          cfg_writes = 0;
  int          cycle_count = 0;
  bit          quiet_in = 1'b0;
  logic [31:0] now = 32'd0;
  logic [31:0] cur_init_timeout = INIT_TIMEOUT_RST;

  self_test_led_status_sequencer #(
    .BLINK_INTERVAL(100),
    .PANIC_PERIOD  (1000)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .command_i    (command),
    .tick_time_i  (tick_time),
    .panic_count_i(panic_count),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_code_o(status_code),
    .power_green_o(power_green),
    .power_red_o  (power_red),
    .aux_leds_o   (aux_leds),
    .time_ended_o (time_ended)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 40);
  endfunction

  function automatic logic [30:0] pick_panic_count();
    logic [31:0] v;
    if ($urandom_range(0, 9) < 4) v = $urandom_range(0, 2147483) * 1000;
    else v = $urandom();
    return v[30:0];
  endfunction

  task automatic send_request(cmd_e cmd, logic [31:0] t, logic [30:0] cnt);
    int gap;
    gap = quiet_in ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    tick_time   <= t;
    panic_count <= cnt;
    do @(posedge clk); while (!in_ready);
    sb.record_request(cmd, t, cnt);
    requests_sent++;
  endtask

  // Holds off new requests until every predicted result has been checked.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  task automatic apply_settings(bit [2:0] which, logic [31:0] post_t, logic [31:0] init_t,
                                logic pat);
    if (which[0]) begin
      cfg_we <= 1'b1; cfg_addr <= CFG_POSTING_TIMEOUT; cfg_wdata <= post_t;
      @(posedge clk);
      sb.write_cfg(CFG_POSTING_TIMEOUT, post_t);
      cfg_writes++;
    end
    if (which[1]) begin
      cfg_we <= 1'b1; cfg_addr <= CFG_INIT_TIMEOUT; cfg_wdata <= init_t;
      @(posedge clk);
      sb.write_cfg(CFG_INIT_TIMEOUT, init_t);
      cur_init_timeout = init_t;
      cfg_writes++;
    end
    if (which[2]) begin
      cfg_we <= 1'b1; cfg_addr <= CFG_PATTERN_MODE; cfg_wdata <= {31'd0, pat};
      @(posedge clk);
      sb.write_cfg(CFG_PATTERN_MODE, {31'd0, pat});
      cfg_writes++;
    end
    if (which != 3'b000) cfg_we <= 1'b0;
  endtask

  task automatic random_settings();
    logic [31:0] post_t;
    logic [31:0] init_t;
    int r;
    r = $urandom_range(0, 2);
    post_t = (r == 0) ? 32'd1 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
    if (post_t == 32'd0) post_t = 32'd1;
    r = $urandom_range(0, 9);
    case (r)
      6: init_t = 32'd1;
      7: init_t = 32'hFFFF_FFFF;
      8: init_t = 32'h8000_0000;
      9: init_t = $urandom();
      default: init_t = $urandom_range(1, 40);
    endcase
    if (init_t == 32'd0) init_t = 32'd1;
    wait_for_results();
    apply_settings(3'($urandom_range(1, 7)), post_t, init_t, 1'($urandom_range(0, 1)));
  endtask

  // Start of init, a run of ticks with some blink steps and panic checks mixed in,
  // then one of the ways the boot can end, and up to three more ticks or panic checks.
  task automatic boot_sequence();
    logic [31:0] start;
    int n;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) now = $urandom();
    else if (r == 1) now = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    else if (r == 2) now = 32'h7FFF_FFF0 + $urandom_range(0, 15);
    else now = now + $urandom_range(1, 500);
    start = now;
    send_request(CMD_START_INIT, now, pick_panic_count());
    n = $urandom_range(1, 30);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        now = now + $urandom_range(1, 4);
        send_request(CMD_TICK, now, 31'($urandom()));
      end else if (r == 7) begin
        send_request(CMD_BLINK_STEP, $urandom(), 31'($urandom()));
      end else if (r == 8) begin
        send_request(CMD_PANIC_CHECK, $urandom(), 31'(($urandom_range(0, 2147482) * 1000) + 7));
      end else begin
        send_request(CMD_PANIC_CHECK, $urandom(), pick_panic_count());
      end
    end
    r = $urandom_range(0, 3);
    case (r)
      0: send_request(CMD_SUCCESS, $urandom(), 31'($urandom()));
      1: begin
        send_request(CMD_ERROR, $urandom(), 31'($urandom()));
        now = now + 1;
        send_request(CMD_TICK, now, 31'($urandom()));
      end
      2: begin
        send_request(CMD_PANIC_CHECK, $urandom(), 31'($urandom_range(0, 2147483) * 1000));
        now = now + 1;
        send_request(CMD_TICK, now, 31'($urandom()));
      end
      default: begin
        now = start + cur_init_timeout + $urandom_range(1, 5);
        send_request(CMD_TICK, now, 31'($urandom()));
      end
    endcase
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      now = now + $urandom_range(1, 100);
      if ($urandom_range(0, 1)) send_request(CMD_TICK, now, 31'($urandom()));
      else send_request(CMD_PANIC_CHECK, now, pick_panic_count());
    end
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(3, 15);
    for (int i = 0; i < n; i++) begin
      send_request(cmd_e'($urandom_range(0, 5)), $urandom(), pick_panic_count());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_leds(status_code, power_green, power_red, aux_leds, time_ended);
    end
  end

  initial begin
    int stall;
    int burst;
    wait (rst_n);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (burst) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL self_test_led_status_sequencer");
    $finish;
  end

  initial begin
    int start_count;
    int kind;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Posting in toggle mode: blinks only on new multiples of the interval.
    send_request(CMD_TICK, 32'd0, 31'd0);
    send_request(CMD_TICK, 32'd100, 31'd0);
    send_request(CMD_TICK, 32'd150, 31'd0);
    send_request(CMD_TICK, 32'd100, 31'd0);
    send_request(CMD_TICK, 32'd200, 31'd0);
    send_request(CMD_BLINK_STEP, 32'd0, 31'd0);
    send_request(CMD_PANIC_CHECK, 32'd0, 31'd999);
    send_request(CMD_PANIC_CHECK, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    wait_for_results();
    apply_settings(3'b101, 32'h7FFF_FFFF, 32'd0, 1'b1);

    // Posting in pattern mode through all five phases.
    for (int i = 3; i <= 7; i++) send_request(CMD_TICK, 32'(i * 100), 31'd0);
    send_request(CMD_BLINK_STEP, 32'd0, 31'd0);
    wait_for_results();
    apply_settings(3'b011, 32'd1, 32'd5, 1'b0);

    // Posting timeout, then commands in the ended states.
    send_request(CMD_TICK, 32'd800, 31'd0);
    send_request(CMD_TICK, 32'd900, 31'd0);
    send_request(CMD_PANIC_CHECK, 32'd0, 31'd0);
    send_request(CMD_SUCCESS, 32'd0, 31'd0);
    send_request(CMD_ERROR, 32'd0, 31'd0);
    send_request(CMD_TICK, 32'd0, 31'd0);
    // Init timeout across the wrap of the tick counter.
    send_request(CMD_START_INIT, 32'hFFFF_FFFC, 31'd0);
    send_request(CMD_TICK, 32'hFFFF_FFFF, 31'd0);
    send_request(CMD_TICK, 32'd1, 31'd0);
    send_request(CMD_TICK, 32'd2, 31'd0);
    send_request(CMD_START_INIT, 32'd0, 31'd0);
    send_request(CMD_PANIC_CHECK, 32'd0, 31'd2147483000);
    send_request(CMD_PANIC_CHECK, 32'd0, 31'd0);
    send_request(CMD_TICK, 32'd3, 31'd0);
    wait_for_results();
    apply_settings(3'b111, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    now = 32'd3;

    start_count = requests_sent;
    while (requests_sent - start_count < RANDOM_ITEMS) begin
      quiet_in = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 3) == 0) random_settings();
      kind = $urandom_range(0, 9);
      if (kind < 7) boot_sequence();
      else if (kind < 9) noise_burst();
      else wait_for_results();
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests, %0d results compared, %0d register writes,",
             requests_sent, sb.matched, cfg_writes);
    $display("both blink modes, posting and init timeouts, panic checks and tick wrap.");
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("PASS self_test_led_status_sequencer");
    end else begin
      $display("FAIL self_test_led_status_sequencer");
    end
    $finish;
  end

endmodule
